// File: hdl/drsb_pkg.sv
// drsb_pkg: shared types and constants of the dot raster strike buffer.
// Holds the item structs, operation codes and the internal command format.
// No dependencies.
package drsb_pkg;

	localparam int DEF_COLUMNS   = 512;
	localparam int DEF_PAGE_ROWS = 64;
	localparam int DEF_MAX_ROWS  = 256;

	// wide enough for any row times any column count
	localparam int CELL_ADDR_W = 28;

	localparam logic [2:0] OP_STRIKE   = 3'd0;
	localparam logic [2:0] OP_ADVANCE  = 3'd1;
	localparam logic [2:0] OP_FORMFEED = 3'd2;
	localparam logic [2:0] OP_CLEAR    = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] column;
		logic [15:0] row;
		logic [7:0]  ink;
		logic [7:0]  advance_count;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  cell_value;
		logic [15:0] paper_row;
		logic [15:0] rows_used;
		logic        cap_reached;
		logic        boundary_valid;
		logic [15:0] boundary_row;
	} out_item_t;

	// classified work for the back end
	typedef enum logic [2:0] {
		K_NOP,
		K_CAP,
		K_STRIKE,
		K_ADVANCE,
		K_FEED,
		K_CLEAR,
		K_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [15:0]            row;
		logic [11:0]            col;
		logic [7:0]             ink;
		logic [7:0]             count;
		logic [CELL_ADDR_W-1:0] row_base;
	} cmd_t;

endpackage

// File: hdl/drsb_ram.sv
// drsb_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module drsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/drsb_fifo.sv
// drsb_fifo: short register queue used between front and back and on the result side.
// Depends on nothing.
module drsb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: hdl/drsb_front.sv
// drsb_front: decodes an incoming item into a back-end command.
// Range checks on column and row, and the row base address of the cell store.
// Depends on drsb_pkg.
module drsb_front
	import drsb_pkg::*;
#(
	parameter int COLUMNS  = DEF_COLUMNS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  in_item_t item,
	output cmd_t     cmd
);

	logic col_ok;
	logic row_ok;

	assign col_ok = ({1'b0, item.column} < 13'(COLUMNS));
	assign row_ok = ({1'b0, item.row} < 17'(MAX_ROWS));

	always_comb begin
		cmd.row      = item.row;
		cmd.col      = item.column;
		cmd.ink      = item.ink;
		cmd.count    = item.advance_count;
		cmd.row_base = {12'd0, item.row} * CELL_ADDR_W'(COLUMNS);
		unique case (item.op)
			OP_STRIKE: begin
				if (!col_ok) begin
					cmd.kind = K_NOP;
				end else if (!row_ok) begin
					cmd.kind = K_CAP;
				end else begin
					cmd.kind = K_STRIKE;
				end
			end
			OP_ADVANCE:  cmd.kind = (item.advance_count == 8'd0) ? K_NOP : K_ADVANCE;
			OP_FORMFEED: cmd.kind = K_FEED;
			OP_CLEAR:    cmd.kind = K_CLEAR;
			OP_READ:     cmd.kind = (col_ok && row_ok) ? K_READ : K_NOP;
			default:     cmd.kind = K_NOP;
		endcase
	end

endmodule

// File: hdl/drsb_back.sv
// drsb_back: carries out commands against the cell store and the paper counters.
// Owns the row valid bits, paper position, page base, used extent and cap flag.
// Depends on drsb_pkg and drsb_ram.
module drsb_back
	import drsb_pkg::*;
#(
	parameter int COLUMNS   = DEF_COLUMNS,
	parameter int PAGE_ROWS = DEF_PAGE_ROWS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_valid,
	output logic      cmd_pop,
	input  logic      res_full,
	output logic      res_push,
	output out_item_t res
);

	localparam int DEPTH    = MAX_ROWS * COLUMNS;
	localparam int AW       = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(COLUMNS);
	localparam int RIDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int MAX_BASE = (MAX_ROWS / PAGE_ROWS) * PAGE_ROWS;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SWEEP = 5'b00010,
		ST_RMW   = 5'b00100,
		ST_NORM  = 5'b01000,
		ST_REPLY = 5'b10000
	} state_t;

	state_t              state_q;
	logic [15:0]         paper_q;
	logic [15:0]         base_q;
	logic [15:0]         used_q;
	logic                cap_q;
	logic [MAX_ROWS-1:0] valid_q;
	logic [CNT_W-1:0]    cnt_q;
	cmd_t                cur_q;
	logic                hit_q;

	logic                   start;
	logic [RIDX_W-1:0]      cmd_idx;
	logic [CELL_ADDR_W-1:0] cmd_addr;
	logic [CELL_ADDR_W-1:0] cur_addr;
	logic [CELL_ADDR_W-1:0] sweep_addr;
	logic [16:0]            adv_target;
	logic [16:0]            feed_target;
	logic [16:0]            base_step;
	logic                   adv_sat;
	logic                   feed_sat;
	logic [15:0]            strike_ext;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [7:0]    rd_data;

	assign start       = (state_q == ST_IDLE) && cmd_valid && !res_full;
	assign cmd_idx     = cmd.row[RIDX_W-1:0];
	assign cmd_addr    = cmd.row_base + CELL_ADDR_W'(cmd.col);
	assign cur_addr    = cur_q.row_base + CELL_ADDR_W'(cur_q.col);
	assign sweep_addr  = cur_q.row_base + CELL_ADDR_W'(cnt_q);
	assign adv_target  = {1'b0, paper_q} + {9'd0, cmd.count};
	assign feed_target = {1'b0, base_q} + 17'(PAGE_ROWS);
	assign base_step   = feed_target;
	assign adv_sat     = (adv_target >= 17'(MAX_ROWS));
	assign feed_sat    = (feed_target >= 17'(MAX_ROWS));
	// row is below the cap here, so row + 1 fits
	assign strike_ext  = cmd.row + 16'd1;

	always_comb begin
		cmd_pop  = start;
		res_push = (state_q == ST_REPLY) && !res_full;
		rd_en    = 1'b0;
		rd_addr  = cmd_addr[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = cur_addr[AW-1:0];
		wr_data  = rd_data | cur_q.ink;
		if (start && ((cmd.kind == K_STRIKE) || (cmd.kind == K_READ)) && valid_q[cmd_idx]) begin
			rd_en = 1'b1;
		end
		if (state_q == ST_RMW) begin
			wr_en = 1'b1;
		end
		if (state_q == ST_SWEEP) begin
			// a fresh row is zeroed, with the struck cell taking the ink on the way
			wr_en   = 1'b1;
			wr_addr = sweep_addr[AW-1:0];
			wr_data = (12'(cnt_q) == cur_q.col) ? cur_q.ink : 8'd0;
		end
	end

	always_comb begin
		res.cell_value     = ((cur_q.kind == K_READ) && hit_q) ? rd_data : 8'd0;
		res.paper_row      = paper_q;
		res.rows_used      = used_q;
		res.cap_reached    = cap_q;
		res.boundary_valid = (cur_q.kind == K_FEED);
		res.boundary_row   = (cur_q.kind == K_FEED) ? paper_q : 16'd0;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= cmd;
			hit_q <= valid_q[cmd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			paper_q <= '0;
			base_q  <= '0;
			used_q  <= '0;
			cap_q   <= 1'b0;
			valid_q <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_REPLY;
						unique case (cmd.kind)
							K_CAP: cap_q <= 1'b1;
							K_STRIKE: begin
								if (strike_ext > used_q) begin
									used_q <= strike_ext;
								end
								if (valid_q[cmd_idx]) begin
									state_q <= ST_RMW;
								end else begin
									valid_q[cmd_idx] <= 1'b1;
									cnt_q            <= '0;
									state_q          <= ST_SWEEP;
								end
							end
							K_ADVANCE: begin
								if (adv_sat) begin
									paper_q <= 16'(MAX_ROWS);
									base_q  <= 16'(MAX_BASE);
									cap_q   <= 1'b1;
									if (16'(MAX_ROWS) > used_q) begin
										used_q <= 16'(MAX_ROWS);
									end
								end else begin
									paper_q <= adv_target[15:0];
									if (adv_target[15:0] > used_q) begin
										used_q <= adv_target[15:0];
									end
									state_q <= ST_NORM;
								end
							end
							K_FEED: begin
								if (feed_sat) begin
									paper_q <= 16'(MAX_ROWS);
									base_q  <= 16'(MAX_BASE);
									cap_q   <= 1'b1;
									if (16'(MAX_ROWS) > used_q) begin
										used_q <= 16'(MAX_ROWS);
									end
								end else begin
									paper_q <= feed_target[15:0];
									base_q  <= feed_target[15:0];
									if (feed_target[15:0] > used_q) begin
										used_q <= feed_target[15:0];
									end
								end
							end
							K_CLEAR: begin
								valid_q <= '0;
								paper_q <= '0;
								base_q  <= '0;
								used_q  <= '0;
								cap_q   <= 1'b0;
							end
							K_READ, K_NOP: ;
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					if (cnt_q == CNT_W'(COLUMNS - 1)) begin
						state_q <= ST_REPLY;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RMW: state_q <= ST_REPLY;
				ST_NORM: begin
					// walk the page base up to the page holding the paper
					if ({1'b0, paper_q} >= base_step) begin
						base_q <= base_step[15:0];
					end else begin
						state_q <= ST_REPLY;
					end
				end
				ST_REPLY: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	drsb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

// File: hdl/dot_raster_strike_buffer.sv
// Dot raster store for a printer head: COLUMNS x MAX_ROWS ink mask bytes in one
// synchronous RAM, plus paper position, page base, used row extent and cap flag.
// Every item gives exactly one result. Items enter a two-entry command queue and
// are executed one at a time: read, form feed, clear, no-op items and an advance that
// hits the cap go straight to the reply state; a strike into a row already struck
// passes through a memory read-modify-write state; the first strike of a row after reset
// or clear passes through a sweep that zeroes the row one cell a cycle; an advance that
// stays below the cap passes through a normalise state that steps the page base up by
// PAGE_ROWS once per page boundary it crosses. No clearing pass at reset: rows carry
// valid bits and an unwritten row reads as zero.
// Depends on drsb_pkg, drsb_front, drsb_fifo, drsb_back, drsb_ram.
module dot_raster_strike_buffer
	import drsb_pkg::*;
#(
	parameter int COLUMNS   = DEF_COLUMNS,
	parameter int PAGE_ROWS = DEF_PAGE_ROWS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  command,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	cmd_t      front_cmd;
	cmd_t      queued_cmd;
	logic      cmd_empty;
	logic      cmd_pop;
	logic      res_full;
	logic      res_push;
	out_item_t back_res;

	drsb_front #(
		.COLUMNS  (COLUMNS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.item (command),
		.cmd  (front_cmd)
	);

	drsb_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (2)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_cmd),
		.full    (full),
		.pop     (cmd_pop),
		.rd_data (queued_cmd),
		.empty   (cmd_empty)
	);

	drsb_back #(
		.COLUMNS   (COLUMNS),
		.PAGE_ROWS (PAGE_ROWS),
		.MAX_ROWS  (MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (queued_cmd),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	drsb_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (2)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (back_res),
		.full    (res_full),
		.pop     (pop),
		.rd_data (result),
		.empty   (empty)
	);

`ifndef SYNTH
	a_paper_capped: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.paper_row <= 16'(MAX_ROWS))
		else $error("paper row beyond cap");

	a_cap_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.cap_reached |-> result.paper_row < 16'(MAX_ROWS))
		else $error("paper at cap without cap flag");

	a_extent: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.rows_used >= result.paper_row)
		else $error("used extent below paper row");

	a_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.boundary_valid |-> result.boundary_row == result.paper_row)
		else $error("boundary row differs from paper row");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for dot_raster_strike_buffer, with a cycle-free raster predictor,
// directed corner items and random strike/read/feed traffic. Depends on drsb_pkg.
module tb
	import drsb_pkg::*;
();

	localparam int COLS  = DEF_COLUMNS;
	localparam int PROWS = DEF_PAGE_ROWS;
	localparam int MROWS = DEF_MAX_ROWS;
	localparam int QUIET_LIMIT = 4000;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  command;
	logic      empty;
	logic      pop;
	out_item_t result;

	// predicted raster state
	logic [7:0]  dots [COLS*MROWS];
	bit          stamped [MROWS];
	int unsigned paper_at;
	int unsigned extent;
	bit          capped;

	out_item_t awaited[$];
	in_item_t  recent_strikes[$];
	int        errors;
	bit        steady;
	int        pop_hold;
	int        quiet;

	dot_raster_strike_buffer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.command(command),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_len();
		int p;
		if (steady)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void move_paper(int unsigned target);
		if (target >= MROWS) begin
			target = MROWS;
			capped = 1'b1;
		end
		paper_at = target;
		if (target > extent)
			extent = target;
	endfunction

	// applies one item to the predicted raster and returns the report it should give
	function automatic out_item_t raster_apply(in_item_t c);
		out_item_t   r;
		int unsigned base;
		r = '0;
		case (c.op)
			OP_STRIKE: begin
				if (c.column < COLS) begin
					if (c.row >= MROWS) begin
						capped = 1'b1;
					end else begin
						base = c.row * COLS;
						if (!stamped[c.row]) begin
							for (int i = 0; i < COLS; i++)
								dots[base + i] = '0;
							stamped[c.row] = 1'b1;
						end
						dots[base + c.column] = dots[base + c.column] | c.ink;
						if (c.row + 1 > extent)
							extent = c.row + 1;
					end
				end
			end
			OP_ADVANCE: begin
				if (c.advance_count != 0)
					move_paper(paper_at + c.advance_count);
			end
			OP_FORMFEED: begin
				move_paper((paper_at / PROWS + 1) * PROWS);
				r.boundary_valid = 1'b1;
				r.boundary_row   = paper_at[15:0];
			end
			OP_CLEAR: begin
				foreach (stamped[i])
					stamped[i] = 1'b0;
				paper_at = 0;
				extent   = 0;
				capped   = 1'b0;
			end
			OP_READ: begin
				if (c.column < COLS && c.row < MROWS && stamped[c.row])
					r.cell_value = dots[c.row * COLS + c.column];
			end
			default: ;
		endcase
		r.paper_row   = paper_at[15:0];
		r.rows_used   = extent[15:0];
		r.cap_reached = capped;
		return r;
	endfunction

	function automatic in_item_t make_item(logic [2:0] op, int col, int row, int ink, int cnt);
		in_item_t c;
		c.op            = op;
		c.column        = col[11:0];
		c.row           = row[15:0];
		c.ink           = ink[7:0];
		c.advance_count = cnt[7:0];
		return c;
	endfunction

	task automatic send_item(input in_item_t item);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push    <= 1'b1;
		command <= item;
		do @(posedge clk); while (full);
		awaited = {awaited, raster_apply(item)};
		if (item.op == OP_STRIKE && item.column < COLS && item.row < MROWS) begin
			recent_strikes = {recent_strikes, item};
			if (recent_strikes.size() > 32)
				void'(recent_strikes.pop_front());
		end
	endtask

	function automatic void field_check(string name, logic [15:0] want_v, logic [15:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
			errors++;
		end
	endfunction

	// result side: random stalls, one assignment per falling edge
	initial begin
		pop = 1'b0;
		pop_hold = 0;
		forever begin
			@(negedge clk);
			if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else begin
				pop_hold = idle_len();
				if (pop_hold == 0) begin
					pop <= 1'b1;
				end else begin
					pop <= 1'b0;
					pop_hold--;
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (awaited.size() == 0) begin
				$display("%0t: result with no item pending, got %p", $time, result);
				errors++;
			end else begin
				want = awaited.pop_front();
				field_check("cell_value", 16'(want.cell_value), 16'(result.cell_value));
				field_check("paper_row", want.paper_row, result.paper_row);
				field_check("rows_used", want.rows_used, result.rows_used);
				field_check("cap_reached", 16'(want.cap_reached), 16'(result.cap_reached));
				field_check("boundary_valid", 16'(want.boundary_valid),
					16'(result.boundary_valid));
				field_check("boundary_row", want.boundary_row, result.boundary_row);
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAIL dot_raster_strike_buffer");
			$finish;
		end
	end

	task automatic test_corner_cases();
		send_item(make_item(OP_READ, 0, 0, 0, 0));          // never struck
		send_item(make_item(OP_STRIKE, 0, 0, 'h01, 0));
		send_item(make_item(OP_STRIKE, 0, 0, 'h80, 0));    // ORs into the same cell
		send_item(make_item(OP_READ, 0, 0, 0, 0));
		send_item(make_item(OP_STRIKE, COLS - 1, MROWS - 1, 'hff, 'hff));
		send_item(make_item(OP_READ, COLS - 1, MROWS - 1, 0, 0));
		send_item(make_item(OP_STRIKE, COLS, 3, 'hff, 0)); // column outside
		send_item(make_item(OP_STRIKE, 4095, 65535, 'hff, 0)); // outside wins over cap
		send_item(make_item(OP_READ, COLS, 0, 0, 0));
		send_item(make_item(OP_READ, 0, MROWS, 0, 0));
		send_item(make_item(OP_READ, 0, 7, 0, 0));
		send_item(make_item(3'd5, 1, 1, 1, 1));
		send_item(make_item(3'd6, 0, 0, 0, 0));
		send_item(make_item(3'd7, 4095, 65535, 255, 255));
		send_item(make_item(OP_STRIKE, 1, MROWS, 'h0f, 0)); // dropped, latches cap
		send_item(make_item(OP_STRIKE, 2, 65535, 'hf0, 0));
		send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
		send_item(make_item(OP_READ, 0, 0, 0, 0));
		send_item(make_item(OP_ADVANCE, 0, 0, 0, 0));
		send_item(make_item(OP_FORMFEED, 0, 0, 0, 0));
		send_item(make_item(OP_ADVANCE, 0, 0, 0, 255));
		send_item(make_item(OP_FORMFEED, 0, 0, 0, 0));     // already at cap
		send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
		send_item(make_item(OP_ADVANCE, 0, 0, 0, PROWS - 1));
		send_item(make_item(OP_FORMFEED, 0, 0, 0, 0));
	endtask

	task automatic test_paper_feed();
		int p;
		for (int n = 0; n < 160; n++) begin
			steady = (n < 60);
			p = $urandom_range(0, 99);
			if (p < 35)
				send_item(make_item(OP_ADVANCE, 0, 0, 0, $urandom_range(1, 20)));
			else if (p < 50)
				send_item(make_item(OP_ADVANCE, 0, 0, 0, $urandom_range(0, 255)));
			else if (p < 80)
				send_item(make_item(OP_FORMFEED, 0, 0, 0, 0));
			else if (p < 88)
				send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
			else if (p < 94)
				send_item(make_item(OP_STRIKE, $urandom_range(0, COLS - 1),
					$urandom_range(0, 7), $urandom_range(0, 255), 0));
			else
				send_item(make_item(OP_READ, $urandom_range(0, COLS - 1),
					$urandom_range(0, 7), 0, 0));
		end
		steady = 1'b0;
	endtask

	task automatic test_strike_read();
		int       p;
		int       q;
		int       col;
		int       row;
		in_item_t hit;
		for (int n = 0; n < 850; n++) begin
			steady = (n < 100);
			p = $urandom_range(0, 99);
			if ($urandom_range(0, 59) == 0) begin
				send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
			end else if (p < 45) begin
				q = $urandom_range(0, 99);
				if (q < 80)
					row = $urandom_range(0, 7);
				else if (q < 92)
					row = $urandom_range(0, MROWS - 1); // may be a fresh row: long zeroing
				else
					row = $urandom_range(MROWS, 65535);
				col = ($urandom_range(0, 19) == 0) ? $urandom_range(COLS, 4095)
					: $urandom_range(0, COLS - 1);
				send_item(make_item(OP_STRIKE, col, row, $urandom_range(0, 255), 0));
			end else if (p < 85 && recent_strikes.size() != 0) begin
				hit = recent_strikes[$urandom_range(0, recent_strikes.size() - 1)];
				send_item(make_item(OP_READ, int'(hit.column), int'(hit.row), 0, 0));
			end else if (p < 92) begin
				send_item(make_item(OP_READ, $urandom_range(0, COLS - 1),
					$urandom_range(0, 15), 0, 0));
			end else if (p < 96) begin
				send_item(make_item(OP_ADVANCE, 0, 0, 0, $urandom_range(0, 40)));
			end else begin
				send_item(make_item(OP_FORMFEED, 0, 0, 0, 0));
			end
		end
		steady = 1'b0;
	endtask

	task automatic test_random_mix();
		int       q;
		in_item_t c;
		for (int n = 0; n < 900; n++) begin
			c.op            = 3'($urandom_range(0, 7));
			c.column        = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 4095))
				: 12'($urandom_range(0, COLS - 1));
			q = $urandom_range(0, 99);
			if (q < 40)
				c.row = 16'($urandom_range(0, 7));
			else if (q < 60)
				c.row = 16'($urandom_range(0, MROWS - 1));
			else
				c.row = 16'($urandom_range(0, 65535));
			c.ink           = 8'($urandom_range(0, 255));
			c.advance_count = 8'($urandom_range(0, 255));
			send_item(c);
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		push     = 1'b0;
		command  = '0;
		errors   = 0;
		steady   = 1'b0;
		quiet    = 0;
		paper_at = 0;
		extent   = 0;
		capped   = 1'b0;
		foreach (stamped[i])
			stamped[i] = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_corner_cases();
		test_paper_feed();
		test_strike_read();
		test_random_mix();
		@(negedge clk);
		push <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("PASS dot_raster_strike_buffer");
		else
			$display("FAIL dot_raster_strike_buffer");
		$finish;
	end

endmodule

// File: files.f
hdl/drsb_pkg.sv
hdl/drsb_ram.sv
hdl/drsb_fifo.sv
hdl/drsb_front.sv
hdl/drsb_back.sv
hdl/dot_raster_strike_buffer.sv
tb/sv/tb.sv
